// File: design/ffd_pkg.sv
// ----------------------------------------------------------------------------
// ffd_pkg
// Shared types and constants for the fixed-length frame deframer.
// ----------------------------------------------------------------------------
package ffd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned POS_W   = 4;
    localparam int unsigned NUM_CELLS = 9;   // frame bytes 1..9

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [WORD_W-1:0] t_word;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [1:0]        t_status;
    typedef logic [1:0]        t_cfg_idx;

    // result status codes
    localparam t_status ST_OK         = 2'd0;
    localparam t_status ST_HEADER_ERR = 2'd1;
    localparam t_status ST_TAIL_ERR   = 2'd2;

    // configuration register indexes
    localparam t_cfg_idx CFG_HEADER = 2'd0;
    localparam t_cfg_idx CFG_TAIL   = 2'd1;

    // frame positions
    localparam t_pos POS_HEADER     = 4'd0;
    localparam t_pos POS_PAY_LAST   = 4'd9;
    localparam t_pos POS_TAIL       = 4'd11;

    localparam t_byte HEADER_RESET  = 8'hA5;
    localparam t_byte TAIL_RESET    = 8'h5A;

endpackage

// File: design/ffd_cell.sv
// ----------------------------------------------------------------------------
// ffd_cell
// One byte cell of the payload shift chain; loads its neighbor on shift.
// ----------------------------------------------------------------------------
module ffd_cell (
    input  logic           i_clk,
    input  logic           i_shift,
    input  ffd_pkg::t_byte i_data,
    output ffd_pkg::t_byte o_data
);

    ffd_pkg::t_byte r_data;
    ffd_pkg::t_byte n_data;

    always_comb begin
        n_data = i_shift ? i_data : r_data;
    end

    // payload only, no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// File: design/fixed_frame_deframer.sv
// ----------------------------------------------------------------------------
// fixed_frame_deframer
// Assembles 12-byte frames (header, payload bytes 1..9, checksum, tail)
// from a byte stream and reports header error, tail error or parsed fields.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; input stalls only while a result is held
//   in the output register by a receiver stall.
// Results: o_valid rises in the cycle after the byte that causes a result
//   (a mismatched header byte or the tail byte) is accepted.
// Payload bytes move down a chain of nine byte cells, one step per accepted
//   payload byte; the tail transaction reads the whole chain at once.
// Reset (synchronous, active low): position to header, output valid clear,
//   header/tail registers to 0xA5/0x5A. Payload cells are not reset.
// ----------------------------------------------------------------------------
module fixed_frame_deframer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // byte input channel
    input  logic                i_valid,
    output logic                o_stall,
    input  ffd_pkg::t_byte      i_rx_byte,
    // result channel
    output logic                o_valid,
    input  logic                i_stall,
    output ffd_pkg::t_status    o_status,
    output ffd_pkg::t_byte      o_byte_value,
    output ffd_pkg::t_word      o_word_a,
    output ffd_pkg::t_word      o_word_b,
    output ffd_pkg::t_word      o_word_c,
    output ffd_pkg::t_word      o_word_d,
    // configuration write channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  ffd_pkg::t_cfg_idx   i_cfg_index,
    input  ffd_pkg::t_byte      i_cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    ffd_pkg::t_byte r_header;
    ffd_pkg::t_byte r_tail;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= ffd_pkg::HEADER_RESET;
            r_tail   <= ffd_pkg::TAIL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                ffd_pkg::CFG_HEADER: r_header <= i_cfg_data;
                ffd_pkg::CFG_TAIL:   r_tail   <= i_cfg_data;
                default: ;           // unknown index ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: the output register decouples the two sides
    // ------------------------------------------------------------------
    logic r_out_valid;
    logic w_accept;

    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    // ------------------------------------------------------------------
    // Position counter and decode
    // ------------------------------------------------------------------
    ffd_pkg::t_pos r_pos;
    ffd_pkg::t_pos n_pos;
    logic          w_at_header;
    logic          w_at_payload;
    logic          w_at_tail;

    // positions 12..15 cannot occur, but decode as header anyway
    assign w_at_header  = (r_pos == ffd_pkg::POS_HEADER) || (r_pos > ffd_pkg::POS_TAIL);
    assign w_at_payload = !w_at_header && (r_pos <= ffd_pkg::POS_PAY_LAST);
    assign w_at_tail    = (r_pos == ffd_pkg::POS_TAIL);

    always_comb begin
        n_pos = r_pos;
        if (w_accept) begin
            if (w_at_header) begin
                n_pos = (i_rx_byte == r_header) ? ffd_pkg::t_pos'(1) : ffd_pkg::POS_HEADER;
            end else if (w_at_tail) begin
                n_pos = ffd_pkg::POS_HEADER;
            end else begin
                n_pos = r_pos + ffd_pkg::t_pos'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= ffd_pkg::POS_HEADER;
        end else begin
            r_pos <= n_pos;
        end
    end

    // ------------------------------------------------------------------
    // Payload chain: cell 0 takes the incoming byte. After nine shifts
    // frame byte n sits in cell 9-n.
    // ------------------------------------------------------------------
    logic           w_shift;
    ffd_pkg::t_byte w_cell [ffd_pkg::NUM_CELLS];

    assign w_shift = w_accept && w_at_payload;

    for (genvar g = 0; g < ffd_pkg::NUM_CELLS; g++) begin : g_cell
        if (g == 0) begin : g_first
            ffd_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_data  (i_rx_byte),
                .o_data  (w_cell[g])
            );
        end else begin : g_rest
            ffd_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_data  (w_cell[g-1]),
                .o_data  (w_cell[g])
            );
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic              w_hdr_err;
    logic              w_done;
    logic              w_tail_ok;
    ffd_pkg::t_status  r_status;
    ffd_pkg::t_byte    r_byte_value;
    ffd_pkg::t_word    r_word_a;
    ffd_pkg::t_word    r_word_b;
    ffd_pkg::t_word    r_word_c;
    ffd_pkg::t_word    r_word_d;

    assign w_hdr_err = w_accept && w_at_header && (i_rx_byte != r_header);
    assign w_done    = w_accept && w_at_tail;
    assign w_tail_ok = (i_rx_byte == r_tail);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_hdr_err || w_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // error results carry zero fields
    always_ff @(posedge i_clk) begin
        if (w_hdr_err || w_done) begin
            if (w_done && w_tail_ok) begin
                r_status     <= ffd_pkg::ST_OK;
                r_byte_value <= w_cell[8];
                r_word_a     <= {w_cell[6], w_cell[7]};
                r_word_b     <= {w_cell[4], w_cell[5]};
                r_word_c     <= {w_cell[2], w_cell[3]};
                r_word_d     <= {w_cell[0], w_cell[1]};
            end else begin
                r_status     <= w_done ? ffd_pkg::ST_TAIL_ERR : ffd_pkg::ST_HEADER_ERR;
                r_byte_value <= '0;
                r_word_a     <= '0;
                r_word_b     <= '0;
                r_word_c     <= '0;
                r_word_d     <= '0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_byte_value = r_byte_value;
    assign o_word_a     = r_word_a;
    assign o_word_b     = r_word_b;
    assign o_word_c     = r_word_c;
    assign o_word_d     = r_word_d;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= ffd_pkg::POS_TAIL)
        else $error("frame position out of range");

    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_at_header && !w_at_tail) |=> (r_pos == $past(r_pos) + 4'd1))
        else $error("mid-frame byte did not advance position");

    a_tail_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> (r_out_valid && r_pos == ffd_pkg::POS_HEADER))
        else $error("tail transaction without result or position reset");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ffd_pkg::ST_OK) |->
            (r_byte_value == 8'd0 && r_word_a == 16'd0 && r_word_d == 16'd0))
        else $error("error result carries nonzero fields");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_status == ffd_pkg::ST_OK || r_status == ffd_pkg::ST_HEADER_ERR
                         || r_status == ffd_pkg::ST_TAIL_ERR))
        else $error("invalid status code");

endmodule

// File: tb/fixed_frame_deframer_tb.sv
// ----------------------------------------------------------------------------
// fixed_frame_deframer_tb
// Self-checking bench for the 12-byte frame deframer. A scoreboard class
// tracks the frame position, the payload bytes and the header/tail settings
// and predicts each status result. The bench runs a short directed set, then
// mostly well-formed frames with random content, with truncated frames and
// line noise mixed in, under several idle/stall mixes and header/tail values.
// ----------------------------------------------------------------------------
module fixed_frame_deframer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CLK_PERIOD  = 4;
    localparam int unsigned RESET_CYC   = 4;
    localparam int unsigned FRAME_LEN   = 12;
    localparam int unsigned PHASE_BYTES = 350;      // random bytes per phase
    localparam int unsigned SETTLE_CYC  = 4;        // settle wait after the results drain
    localparam int unsigned DRAIN_LIMIT = 20000;
    localparam int unsigned TIMEOUT_NS  = 2_000_000;

    // indexes past the two real registers; writes there must be ignored
    localparam ffd_pkg::t_cfg_idx CFG_SPARE_LO = 2'd2;
    localparam ffd_pkg::t_cfg_idx CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        ffd_pkg::t_status status;
        ffd_pkg::t_byte   byte_value;
        ffd_pkg::t_word   word_a;
        ffd_pkg::t_word   word_b;
        ffd_pkg::t_word   word_c;
        ffd_pkg::t_word   word_d;
    } t_frame_result;

    // ------------------------------------------------------------------------
    // Frame tracker: mirrors the deframer state and queues expected results
    // ------------------------------------------------------------------------
    class frame_scoreboard;
        ffd_pkg::t_byte  header_val;
        ffd_pkg::t_byte  tail_val;
        ffd_pkg::t_pos   position;
        ffd_pkg::t_byte  payload [ffd_pkg::NUM_CELLS];
        t_frame_result   expected [$];
        int unsigned     errors;
        int unsigned     n_bytes;
        int unsigned     n_ok;
        int unsigned     n_hdr_err;
        int unsigned     n_tail_err;

        function new();
            header_val = ffd_pkg::HEADER_RESET;
            tail_val   = ffd_pkg::TAIL_RESET;
            position   = ffd_pkg::POS_HEADER;
            foreach (payload[i]) payload[i] = '0;
            errors     = 0;
            n_bytes    = 0;
            n_ok       = 0;
            n_hdr_err  = 0;
            n_tail_err = 0;
        endfunction

        function void write_reg(ffd_pkg::t_cfg_idx idx, ffd_pkg::t_byte val);
            case (idx)
                ffd_pkg::CFG_HEADER: header_val = val;
                ffd_pkg::CFG_TAIL:   tail_val   = val;
                default: ;
            endcase
        endfunction

        // one accepted byte transaction
        function void note_byte(ffd_pkg::t_byte b);
            t_frame_result r;
            ffd_pkg::t_pos pos;
            pos = (position > ffd_pkg::POS_TAIL) ? ffd_pkg::POS_HEADER : position;
            r   = '0;
            n_bytes++;
            if (pos == ffd_pkg::POS_HEADER) begin
                if (b != header_val) begin
                    r.status = ffd_pkg::ST_HEADER_ERR;
                    expected.push_back(r);
                    position = ffd_pkg::POS_HEADER;
                end else begin
                    position = pos + 1'b1;
                end
            end else if (pos <= ffd_pkg::POS_PAY_LAST) begin
                payload[pos - 1'b1] = b;
                position = pos + 1'b1;
            end else if (pos < ffd_pkg::POS_TAIL) begin
                position = pos + 1'b1;         // checksum, not checked
            end else begin
                position = ffd_pkg::POS_HEADER;
                if (b != tail_val) begin
                    r.status = ffd_pkg::ST_TAIL_ERR;
                end else begin
                    r.status     = ffd_pkg::ST_OK;
                    r.byte_value = payload[0];
                    r.word_a     = {payload[2], payload[1]};
                    r.word_b     = {payload[4], payload[3]};
                    r.word_c     = {payload[6], payload[5]};
                    r.word_d     = {payload[8], payload[7]};
                end
                expected.push_back(r);
            end
        endfunction

        function void compare_field(string name, ffd_pkg::t_word want,
                                    ffd_pkg::t_word got);
            if (want !== got) begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        // one accepted result transaction
        function void check_result(t_frame_result got);
            t_frame_result want;
            if (expected.size() == 0) begin
                $error("result with nothing expected: status %0d", got.status);
                errors++;
                return;
            end
            want = expected.pop_front();
            case (want.status)
                ffd_pkg::ST_OK:         n_ok++;
                ffd_pkg::ST_HEADER_ERR: n_hdr_err++;
                default:                n_tail_err++;
            endcase
            compare_field("status",     ffd_pkg::t_word'(want.status),
                          ffd_pkg::t_word'(got.status));
            compare_field("byte_value", ffd_pkg::t_word'(want.byte_value),
                          ffd_pkg::t_word'(got.byte_value));
            compare_field("word_a",     want.word_a,     got.word_a);
            compare_field("word_b",     want.word_b,     got.word_b);
            compare_field("word_c",     want.word_c,     got.word_c);
            compare_field("word_d",     want.word_d,     got.word_d);
        endfunction

        function void flush_leftovers();
            while (expected.size() != 0) begin
                $error("missing result: status %0d never arrived",
                       expected[0].status);
                void'(expected.pop_front());
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals; every input known from time zero
    // ------------------------------------------------------------------------
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_valid     = 1'b0;
    logic              o_stall;
    ffd_pkg::t_byte    i_rx_byte   = '0;
    logic              o_valid;
    logic              i_stall     = 1'b0;
    ffd_pkg::t_status  o_status;
    ffd_pkg::t_byte    o_byte_value;
    ffd_pkg::t_word    o_word_a;
    ffd_pkg::t_word    o_word_b;
    ffd_pkg::t_word    o_word_c;
    ffd_pkg::t_word    o_word_d;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    ffd_pkg::t_cfg_idx i_cfg_index = ffd_pkg::CFG_HEADER;
    ffd_pkg::t_byte    i_cfg_data  = '0;

    // idle knobs (percent of cycles), changed per phase
    int unsigned byte_gap_pct     = 0;
    int unsigned result_stall_pct = 0;

    frame_scoreboard sb = new();

    fixed_frame_deframer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_rx_byte    (i_rx_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_byte_value (o_byte_value),
        .o_word_a     (o_word_a),
        .o_word_b     (o_word_b),
        .o_word_c     (o_word_c),
        .o_word_d     (o_word_d),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #(CLK_PERIOD / 2.0) i_clk = ~i_clk;

    // Result side: random back-pressure, one NBA per edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 99) < result_stall_pct);
        end
    end

    // Result monitor. Runs right after the edge, so it sees pre-edge values:
    // a transaction happened at this edge iff valid was high and stall low.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result('{o_status, o_byte_value, o_word_a, o_word_b,
                              o_word_c, o_word_d});
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        #(TIMEOUT_NS * 1ns);
        $display("fixed_frame_deframer regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // One byte transaction. Valid stays high across back-to-back bytes and
    // drops only during a random gap or a drain, so it never toggles within a step.
    task automatic send_byte(input ffd_pkg::t_byte b);
        while ($urandom_range(0, 99) < byte_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        sb.note_byte(b);
    endtask

    // Register write; the caller drops cfg valid after the last one.
    task automatic write_reg(input ffd_pkg::t_cfg_idx idx, input ffd_pkg::t_byte val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
    endtask

    // Spare-index writes sit between the real ones so that a decode slip
    // would clobber the header value before the tail is set.
    task automatic configure(input ffd_pkg::t_byte hdr, input ffd_pkg::t_byte tl,
                             input bit poke_spare);
        write_reg(ffd_pkg::CFG_HEADER, hdr);
        if (poke_spare) begin
            write_reg(CFG_SPARE_LO, ffd_pkg::t_byte'($urandom));
            write_reg(CFG_SPARE_HI, ~hdr);
        end
        write_reg(ffd_pkg::CFG_TAIL, tl);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait for every pending result, then let the block settle so that it
    // is idle before the next register write.
    task automatic drain_results();
        int unsigned waited;
        waited  = 0;
        i_valid <= 1'b0;
        while (sb.expected.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        sb.flush_leftovers();
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Payload byte biased toward the extremes and toward the header value,
    // which must not resync the frame when it shows up mid-frame.
    function automatic ffd_pkg::t_byte payload_byte();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return sb.header_val;
            default: return ffd_pkg::t_byte'($urandom);
        endcase
    endfunction

    // A frame of len bytes; len below FRAME_LEN gives a truncated frame.
    task automatic send_frame(input int unsigned len, input bit good_tail);
        ffd_pkg::t_byte b;
        for (int unsigned i = 0; i < len; i++) begin
            if (i == 0)
                b = sb.header_val;
            else if (i == FRAME_LEN - 1)
                b = good_tail ? sb.tail_val
                              : sb.tail_val ^ ffd_pkg::t_byte'($urandom_range(1, 255));
            else
                b = payload_byte();
            send_byte(b);
        end
    endtask

    // Mostly clean frames; the rest bad tails, truncations and noise.
    task automatic run_random(input int unsigned n_items);
        int unsigned start;
        int unsigned pick;
        start = sb.n_bytes;
        while (sb.n_bytes - start < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_frame(FRAME_LEN, 1'b1);
            else if (pick < 82)
                send_frame(FRAME_LEN, 1'b0);
            else if (pick < 90)
                send_frame($urandom_range(2, FRAME_LEN - 1), 1'b1);
            else
                repeat ($urandom_range(1, 4)) send_byte(ffd_pkg::t_byte'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        ffd_pkg::t_byte directed [] = '{
            // clean frame with extreme payload, reset header/tail values
            ffd_pkg::HEADER_RESET, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00,
            8'h12, 8'h34, 8'h00, 8'h00, 8'h77, ffd_pkg::TAIL_RESET,
            // wrong header byte
            8'h00,
            // header value inside the frame, then a bad tail
            ffd_pkg::HEADER_RESET, ffd_pkg::HEADER_RESET, ffd_pkg::HEADER_RESET,
            8'h01, 8'h80, 8'hFE, 8'h7F, 8'h55, 8'hAA, ffd_pkg::HEADER_RESET,
            8'h00, 8'h00
        };

        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed set against the reset-time header/tail values
        foreach (directed[i]) send_byte(directed[i]);
        drain_results();

        // phases: no idling, sender gaps, receiver stalls, both lightly
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    configure(ffd_pkg::HEADER_RESET, ffd_pkg::TAIL_RESET, 1'b1);
                    byte_gap_pct = 0;  result_stall_pct = 0;
                end
                1: begin
                    configure(8'h00, 8'hFF, 1'b0);
                    byte_gap_pct = 84; result_stall_pct = 0;
                end
                2: begin
                    configure(8'hFF, 8'h00, 1'b1);
                    byte_gap_pct = 0;  result_stall_pct = 84;
                end
                default: begin
                    configure(ffd_pkg::t_byte'($urandom), ffd_pkg::t_byte'($urandom), 1'b0);
                    byte_gap_pct = 18; result_stall_pct = 18;
                end
            endcase
            run_random(PHASE_BYTES);
            drain_results();
        end

        repeat (SETTLE_CYC) @(posedge i_clk);
        $display("Ran %0d bytes through four idle/stall mixes and header/tail settings.",
                 sb.n_bytes);
        $display("Results seen: %0d frames ok, %0d header errors, %0d tail errors.",
                 sb.n_ok, sb.n_hdr_err, sb.n_tail_err);
        if (sb.errors == 0) begin
            $display("fixed_frame_deframer regression: pass");
        end else begin
            $display("fixed_frame_deframer regression: fail");
        end
        $finish;
    end

endmodule
